/* rtl/postfix_stack_evaluator_core_defines.svh */
// Assertion macros for the postfix stack evaluator.
`ifndef POSTFIX_STACK_EVALUATOR_CORE_DEFINES_SVH
`define POSTFIX_STACK_EVALUATOR_CORE_DEFINES_SVH
// Assert an implication on the rising clock edge, off during reset.
`define PSE_ASSERT_IMP(label, clk_s, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk_s) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`endif

/* rtl/pse_pkg.sv */
// Package: types and constants for the postfix stack evaluator.
`default_nettype none
package pse_pkg;
	localparam int STACK_DEPTH_DEF = 16;
	localparam int DATA_W = 32;

	typedef enum logic [2:0] {
		K_PUSH = 3'd0, K_ADD = 3'd1, K_SUB = 3'd2, K_MUL = 3'd3,
		K_DIV = 3'd4, K_POW = 3'd5, K_FIN = 3'd6, K_NOP = 3'd7
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0, ST_UNDER = 2'd1, ST_OVER = 2'd2, ST_DIVZ = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE, S_RD1, S_RD2, S_EXEC, S_DIV, S_DIVFIX, S_POW, S_POWSQ, S_WB, S_TOPRD, S_TOP,
		S_REPLY
	} state_t;

	typedef enum logic [1:0] {
		OPR_ADD, OPR_SUB, OPR_MUL
	} alu_op_t;

	// Controller to datapath
	typedef struct packed {
		logic       latch_in;
		logic       rd_top;
		logic       rd_next;
		logic       rd_res;
		logic       cap_r;
		logic       alu_go;
		logic       div_init;
		logic       div_step;
		logic       div_fix;
		logic       pow_init;
		logic       pow_mul;
		logic       pow_sq;
		logic       wr_push;
		logic       wr_res;
		logic       cnt_inc;
		logic       cnt_dec;
		logic       cnt_clr;
		logic       set_val_top;
		logic       set_val_zero;
		logic       set_val_r;
		logic       strobe;
		status_t    status;
		logic       done;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		kind_t kind;
		logic  empty;
		logic  full;
		logic  lt2;
		logic  r_zero;
		logic  pow_neg;
		logic  pow_done;
		logic  div_last;
	} sts_t;
endpackage
`default_nettype wire

/* rtl/postfix_stack_evaluator_core.sv */
// Top level of the postfix stack evaluator.
`default_nettype none
// Takes one token per request (start while busy is low) and returns exactly one
// result, shown for a single cycle with strobe high in the cycle that busy drops;
// the receiver cannot stall. Busy stays high while the request is worked on; divide
// takes one quotient bit a cycle over 32 bits and power does a multiply and a square
// per exponent bit. The single-port stack RAM sets the length of the short cases.
module postfix_stack_evaluator_core import pse_pkg::*; #(
	parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire logic [2:0]        kind,
	input  wire logic [DATA_W-1:0] operand,
	output logic                   strobe,
	output logic [DATA_W-1:0]      top_value,
	output logic [1:0]             status,
	output logic                   done_res
);
	cmd_t cmd;
	sts_t sts;
	logic strobe_q;

	pse_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .sts(sts), .cmd(cmd)
	);

	pse_datapath #(.STACK_DEPTH(STACK_DEPTH)) u_dp (
		.clk(clk), .arst_n(arst_n), .kind(kind), .operand(operand), .cmd(cmd), .sts(sts),
		.top_value(top_value), .status(status), .done_res(done_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= cmd.strobe;
		end
	end
	assign strobe = strobe_q;
endmodule
`default_nettype wire

/* rtl/pse_ram.sv */
// Generic single-port RAM with registered read.
`default_nettype none
module pse_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule
`default_nettype wire

/* rtl/pse_datapath.sv */
// Datapath: stack memory, count, operand registers, serial divider and power unit.
`default_nettype none
module pse_datapath import pse_pkg::*; #(
	parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic [2:0]          kind,
	input  wire logic [DATA_W-1:0]   operand,
	input  wire cmd_t                cmd,
	output sts_t                     sts,
	output logic [DATA_W-1:0]        top_value,
	output logic [1:0]               status,
	output logic                     done_res
);
	localparam int AW = $clog2(STACK_DEPTH);
	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam int IW = $clog2(DATA_W);

	logic [CW-1:0]     cnt_q;
	kind_t             kind_q;
	logic [DATA_W-1:0] opnd_q, r_q, res_q;
	logic [DATA_W-1:0] rdata;
	logic [AW-1:0]     addr;
	logic              we;
	logic [DATA_W-1:0] wdata;
	// divider
	logic [DATA_W-1:0] rem_q, quo_q, dvs_q;
	logic [IW-1:0]     dcnt_q;
	logic              neg_q;
	logic [DATA_W:0]   trial;
	logic [DATA_W-1:0] rem_sh;
	// power
	logic [DATA_W-1:0] base_q, ex_q, acc_q;
	logic [DATA_W-1:0] out_val_q;
	logic [1:0]        out_st_q;
	logic              out_done_q, out_stb_q;

	always_comb begin
		addr = '0;
		if (cmd.rd_top || cmd.wr_res || cmd.rd_res) begin
			addr = AW'(cnt_q - CW'(1));
		end
		if (cmd.rd_next) begin
			addr = AW'(cnt_q - CW'(2));
		end
		if (cmd.wr_push) begin
			addr = AW'(cnt_q);
		end
		if (cmd.wr_res) begin
			addr = AW'(cnt_q - CW'(2));
		end
	end
	assign we    = cmd.wr_push | cmd.wr_res;
	assign wdata = cmd.wr_push ? opnd_q : res_q;

	pse_ram #(.WIDTH(DATA_W), .DEPTH(STACK_DEPTH)) u_stack (
		.clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			kind_q <= K_NOP;
			out_stb_q <= 1'b0;
		end else begin
			out_stb_q <= cmd.strobe;
			if (cmd.latch_in) begin
				kind_q <= kind_t'(kind);
			end
			if (cmd.cnt_clr) begin
				cnt_q <= '0;
			end else if (cmd.cnt_inc) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (cmd.cnt_dec) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	assign trial  = {1'b0, rem_sh} - {1'b0, dvs_q};
	assign rem_sh = {rem_q[DATA_W-2:0], quo_q[DATA_W-1]};

	// left operand arrives on rdata in the cycle that starts the operation
	always_ff @(posedge clk) begin
		if (cmd.latch_in) begin
			opnd_q <= operand;
		end
		if (cmd.cap_r) begin
			r_q <= rdata;
		end
		if (cmd.alu_go) begin
			unique case (kind_q)
				K_ADD:   res_q <= rdata + r_q;
				K_SUB:   res_q <= rdata - r_q;
				K_MUL:   res_q <= rdata * r_q;
				default: res_q <= '0;
			endcase
		end
		if (cmd.div_init) begin
			rem_q  <= '0;
			quo_q  <= rdata[DATA_W-1] ? -rdata : rdata;
			dvs_q  <= r_q[DATA_W-1] ? -r_q : r_q;
			neg_q  <= rdata[DATA_W-1] ^ r_q[DATA_W-1];
			dcnt_q <= '0;
		end
		if (cmd.div_step) begin
			dcnt_q <= dcnt_q + IW'(1);
			if (!trial[DATA_W]) begin
				rem_q <= trial[DATA_W-1:0];
				quo_q <= {quo_q[DATA_W-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				quo_q <= {quo_q[DATA_W-2:0], 1'b0};
			end
		end
		if (cmd.div_fix) begin
			res_q <= neg_q ? -quo_q : quo_q;
		end
		if (cmd.pow_init) begin
			base_q <= rdata;
			ex_q   <= r_q;
			acc_q  <= DATA_W'(1);
			if (r_q[DATA_W-1]) begin
				if (rdata == DATA_W'(1)) begin
					res_q <= DATA_W'(1);
				end else if (rdata == '1) begin
					res_q <= r_q[0] ? '1 : DATA_W'(1);
				end else begin
					res_q <= '0;
				end
			end
		end
		if (cmd.pow_mul && ex_q[0]) begin
			acc_q <= acc_q * base_q;
		end
		if (cmd.pow_mul && ex_q == '0) begin
			res_q <= acc_q;
		end
		if (cmd.pow_sq) begin
			base_q <= base_q * base_q;
			ex_q   <= ex_q >> 1;
		end
		if (cmd.strobe) begin
			out_val_q  <= cmd.set_val_zero ? '0 : (cmd.set_val_r ? r_q : rdata);
			out_st_q   <= cmd.status;
			out_done_q <= cmd.done;
		end
	end

	assign sts.kind     = kind_q;
	assign sts.empty    = (cnt_q == '0);
	assign sts.full     = (cnt_q >= CW'(STACK_DEPTH));
	assign sts.lt2      = (cnt_q < CW'(2));
	assign sts.r_zero   = (r_q == '0);
	assign sts.pow_neg  = r_q[DATA_W-1];
	assign sts.pow_done = (ex_q == '0);
	assign sts.div_last = (dcnt_q == IW'(DATA_W - 1));

	assign top_value = out_val_q;
	assign status    = out_st_q;
	assign done_res  = out_stb_q & out_done_q;
endmodule
`default_nettype wire

/* rtl/pse_ctrl.sv */
// Controller: sequences stack reads, arithmetic and write-back for each request.
`default_nettype none
module pse_ctrl import pse_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	output logic      busy,
	input  wire sts_t sts,
	output cmd_t      cmd
);
	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:   if (start) state_d = S_RD1;
			S_RD1: begin
				unique case (sts.kind)
					K_PUSH:  state_d = sts.full ? S_REPLY : S_TOPRD;
					K_FIN:   state_d = sts.empty ? S_REPLY : S_TOP;
					K_NOP:   state_d = sts.empty ? S_REPLY : S_TOP;
					default: state_d = sts.lt2 ? S_REPLY : S_RD2;
				endcase
			end
			S_RD2:    state_d = S_EXEC;
			S_EXEC: begin
				unique case (sts.kind)
					K_DIV:   state_d = sts.r_zero ? S_REPLY : S_DIV;
					K_POW:   state_d = sts.pow_neg ? S_WB : S_POW;
					default: state_d = S_WB;
				endcase
			end
			S_DIV:    if (sts.div_last) state_d = S_DIVFIX;
			S_DIVFIX: state_d = S_WB;
			S_POW:    state_d = sts.pow_done ? S_WB : S_POWSQ;
			S_POWSQ:  state_d = S_POW;
			S_WB:     state_d = S_TOPRD;
			S_TOPRD:  state_d = S_TOP;
			S_TOP:    state_d = S_IDLE;
			S_REPLY:  state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.status = ST_OK;
		busy = (state_q != S_IDLE);
		unique case (state_q)
			S_IDLE:  cmd.latch_in = start;
			S_RD1: begin
				cmd.rd_top = 1'b1;
				if (sts.kind == K_PUSH && !sts.full) begin
					cmd.rd_top  = 1'b0;
					cmd.wr_push = 1'b1;
					cmd.cnt_inc = 1'b1;
				end
			end
			S_RD2: begin
				cmd.rd_next = 1'b1;
				cmd.cap_r   = 1'b1;
			end
			S_EXEC: begin
				cmd.alu_go   = (sts.kind == K_ADD) || (sts.kind == K_SUB) ||
					(sts.kind == K_MUL);
				cmd.div_init = (sts.kind == K_DIV);
				cmd.pow_init = (sts.kind == K_POW);
			end
			S_DIV:    cmd.div_step = 1'b1;
			S_DIVFIX: cmd.div_fix = 1'b1;
			S_POW:    cmd.pow_mul = 1'b1;
			S_POWSQ:  cmd.pow_sq = 1'b1;
			S_WB: begin
				cmd.wr_res  = 1'b1;
				cmd.cnt_dec = 1'b1;
			end
			S_TOPRD:  cmd.rd_top = 1'b1;
			S_TOP: begin
				cmd.strobe = 1'b1;
				if (sts.kind == K_FIN) begin
					cmd.done    = 1'b1;
					cmd.cnt_clr = 1'b1;
				end
			end
			S_REPLY: begin
				cmd.strobe = 1'b1;
				unique case (sts.kind)
					K_PUSH: begin
						cmd.status = ST_OVER;
						cmd.rd_top = 1'b1;
					end
					K_FIN: begin
						cmd.status = ST_UNDER;
						cmd.set_val_zero = 1'b1;
					end
					K_NOP:  cmd.set_val_zero = 1'b1;
					K_DIV: begin
						cmd.status = sts.lt2 ? ST_UNDER : ST_DIVZ;
						cmd.set_val_zero = sts.empty;
						cmd.set_val_r = !sts.lt2;
					end
					default: begin
						cmd.status = ST_UNDER;
						cmd.set_val_zero = sts.empty;
					end
				endcase
			end
			default: ;
		endcase
	end
endmodule
`default_nettype wire

/* rtl/pse_checker.sv */
// Port checker for the postfix stack evaluator, bound to the top level.
`default_nettype none
`include "postfix_stack_evaluator_core_defines.svh"
module pse_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        start,
	input wire logic        busy,
	input wire logic        strobe,
	input wire logic [1:0]  status,
	input wire logic        done_res
);
	`PSE_ASSERT_IMP(a_acc_busy, clk, arst_n, start && !busy, ##1 busy, "accept without busy")
	`PSE_ASSERT_IMP(a_done_ok, clk, arst_n, done_res, strobe && status == 2'd0, "bad done")
	`PSE_ASSERT_IMP(a_strobe_one, clk, arst_n, strobe, ##1 !strobe, "strobe too long")
	`PSE_ASSERT_IMP(a_idle_quiet, clk, arst_n, !busy && !$past(busy), !strobe, "idle strobe")
endmodule

bind postfix_stack_evaluator_core pse_checker u_chk (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .strobe(strobe),
	.status(status), .done_res(done_res)
);
`default_nettype wire
